// ===== sv/pet_pkg.sv =====
// Shared types and constants of the proximity entry trigger.
`default_nettype none
package pet_pkg;

   // item commands
   localparam logic [1:0] CMD_WRITE_POINT = 2'd0;
   localparam logic [1:0] CMD_CLEAR_MARKS = 2'd1;
   localparam logic [1:0] CMD_STEP_MOVER  = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_POINTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONNECT_RADIUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_HEIGHT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_SPAN_MV  = 2'd3;

   // register reset values
   localparam logic [6:0]  RST_ACTIVE_POINTS  = 7'd16;
   localparam logic [11:0] RST_CONNECT_RADIUS = 12'd640;
   localparam logic [11:0] RST_FIELD_HEIGHT   = 12'd2144;
   localparam logic [12:0] RST_PITCH_SPAN_MV  = 13'd2000;

   // fixed field widths
   localparam int CMD_W   = 2;
   localparam int PIDX_W  = 6;
   localparam int MIDX_W  = 2;
   localparam int PITCH_W = 14;
   localparam int DIST_W  = 13;
   localparam int HGT_W   = 12;
   localparam int SPAN_W  = 13;

   localparam logic [SPAN_W-1:0] SPAN_LIMIT = 13'd5000;

   // status of an iterative arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } pet_unit_stat_type;

endpackage
`default_nettype wire

// ===== sv/pet_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface pet_req_if #(parameter int COORD_BITS = 12) ();
   logic                          valid;
   logic                          ready;
   logic [pet_pkg::CMD_W-1:0]     cmd;
   logic [pet_pkg::PIDX_W-1:0]    point_index;
   logic [pet_pkg::MIDX_W-1:0]    mover_index;
   logic [COORD_BITS-1:0]         pos_x;
   logic [COORD_BITS-1:0]         pos_y;

   modport source (output valid, cmd, point_index, mover_index, pos_x, pos_y, input ready);
   modport sink   (input valid, cmd, point_index, mover_index, pos_x, pos_y, output ready);
endinterface

interface pet_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic                              entered;
   logic [pet_pkg::PIDX_W-1:0]        entered_point;
   logic signed [pet_pkg::PITCH_W-1:0] pitch_mv;
   logic [pet_pkg::DIST_W-1:0]        nearest_dist;

   modport source (output valid, entered, entered_point, pitch_mv, nearest_dist, input ready);
   modport sink   (input valid, entered, entered_point, pitch_mv, nearest_dist, output ready);
endinterface
`default_nettype wire

// ===== sv/pet_cell.sv =====
// One point cell of the rotating point ring.
`default_nettype none
module pet_cell #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  shift_en,
   input  wire logic [COORD_BITS-1:0] shift_x,
   input  wire logic [COORD_BITS-1:0] shift_y,
   input  wire logic                  load_en,
   input  wire logic [COORD_BITS-1:0] load_x,
   input  wire logic [COORD_BITS-1:0] load_y,
   output logic      [COORD_BITS-1:0] x,
   output logic      [COORD_BITS-1:0] y
);
   logic [COORD_BITS-1:0] x_ff, x_in;
   logic [COORD_BITS-1:0] y_ff, y_in;

   // load has priority; otherwise take the neighbor's point while rotating
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (load_en) begin
         x_in = load_x;
         y_in = load_y;
      end else if (shift_en) begin
         x_in = shift_x;
         y_in = shift_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign x = x_ff;
   assign y = y_ff;
endmodule
`default_nettype wire

// ===== sv/pet_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
`default_nettype none
module pet_sqrt #(
   parameter int IN_W = 26
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [IN_W-1:0]            value,
   output pet_pkg::pet_unit_stat_type      stat,
   output logic      [IN_W/2-1:0]          root
);
   import pet_pkg::*;

   localparam int HW    = IN_W / 2;
   localparam int RW    = HW + 3;
   localparam int CNT_W = $clog2(HW + 1);

   logic [IN_W-1:0]  val_ff, val_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [HW-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RW-1:0]    rem_sh, trial;

   // bring down two bits, try appending a one
   always_comb begin
      rem_sh  = {rem_ff[RW-3:0], val_ff[IN_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         val_in = {val_ff[IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[HW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[HW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(HW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign root      = root_ff;
endmodule
`default_nettype wire

// ===== sv/pet_div.sv =====
// Iterative unsigned restoring divider, one quotient bit per cycle.
`default_nettype none
module pet_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_W-1:0]      dividend,
   input  wire logic [DEN_W-1:0]      divisor,
   output pet_pkg::pet_unit_stat_type stat,
   output logic      [NUM_W-1:0]      quotient
);
   import pet_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh, rem_sub;

   // shift the next dividend bit into the remainder and subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sub[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
endmodule
`default_nettype wire

// ===== sv/proximity_entry_trigger_core.sv =====
// Top level of the proximity entry trigger.
//
// The points sit in a ring of MAX_POINTS cells. A step_mover item rotates the
// ring once around, feeding one point per cycle into a two-stage
// distance/compare pipeline that updates the mover's marks and tracks the
// nearest point and the nearest newly entered one. Then the floor square
// root and the pitch division run on serial units, of which the divider is
// the longer. Other items go straight to their result. A new item is taken
// once the previous one has handed its result to the output register. No
// clearing pass is needed: marks rows carry valid bits that reset and
// clear_marks drop at once.
`default_nettype none
module proximity_entry_trigger_core #(
   parameter int MAX_POINTS = 64,
   parameter int NUM_MOVERS = 4,
   parameter int COORD_BITS = 12
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pet_req_if.sink                               req_chan,
   pet_rsp_if.source                             rsp_chan,
   input  wire logic                             csr_we,
   input  wire logic [pet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [pet_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pet_pkg::*;

   localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int MV_W    = (NUM_MOVERS > 1) ? $clog2(NUM_MOVERS) : 1;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int D2_W    = SQ_W + 1;
   localparam int SQI_W   = SQ_W + 2;
   localparam int ROOT_W  = SQI_W / 2;
   localparam int R2_W    = 24;
   localparam int DIFF_W  = ((COORD_BITS > HGT_W) ? COORD_BITS : HGT_W) + 2;
   localparam int PROD_W  = DIFF_W + 15;
   localparam int NUM_W   = PROD_W + 1;
   localparam int DEN_W   = HGT_W + 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_FLUSH  = 3'd2;
   localparam logic [2:0] ST_PITCH1 = 3'd3;
   localparam logic [2:0] ST_PITCH2 = 3'd4;
   localparam logic [2:0] ST_WAIT   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   // configuration registers
   logic [6:0]        act_ff;
   logic [11:0]       radius_ff;
   logic [HGT_W-1:0]  height_ff;
   logic [SPAN_W-1:0] span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= RST_ACTIVE_POINTS;
         radius_ff <= RST_CONNECT_RADIUS;
         height_ff <= RST_FIELD_HEIGHT;
         span_ff   <= RST_PITCH_SPAN_MV;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_POINTS:  act_ff    <= csr_wdata[6:0];
            CSR_CONNECT_RADIUS: radius_ff <= csr_wdata[11:0];
            CSR_FIELD_HEIGHT:   height_ff <= csr_wdata[HGT_W-1:0];
            CSR_PITCH_SPAN_MV:  span_ff   <= csr_wdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // effective span and height
   logic [SPAN_W-1:0] span_eff;
   logic [HGT_W-1:0]  h_eff;
   assign span_eff = (span_ff > SPAN_LIMIT) ? SPAN_LIMIT : span_ff;
   assign h_eff    = (height_ff == '0) ? HGT_W'(1) : height_ff;

   // control state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  n_ff;
   logic [MV_W-1:0]   midx_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff;
   logic [R2_W-1:0]   r2_ff;
   logic              accept;
   logic              is_step;
   logic              write_hit;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign is_step   = (req_chan.cmd == CMD_STEP_MOVER) &&
                      (32'(req_chan.mover_index) < NUM_MOVERS);
   assign write_hit = accept && (req_chan.cmd == CMD_WRITE_POINT) &&
                      (32'(req_chan.point_index) < MAX_POINTS);

   // point ring
   logic [COORD_BITS-1:0] cell_x [MAX_POINTS];
   logic [COORD_BITS-1:0] cell_y [MAX_POINTS];
   logic                  ring_shift;
   assign ring_shift = (state_ff == ST_SCAN);

   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pet_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock    (clock),
         .shift_en (ring_shift),
         .shift_x  (cell_x[(i + 1) % MAX_POINTS]),
         .shift_y  (cell_y[(i + 1) % MAX_POINTS]),
         .load_en  (write_hit && (IDX_W'(req_chan.point_index) == IDX_W'(i))),
         .load_x   (req_chan.pos_x),
         .load_y   (req_chan.pos_y),
         .x        (cell_x[i]),
         .y        (cell_y[i])
      );
   end

   // stage 0: squared differences of the head cell
   logic [COORD_BITS-1:0] dx, dy;
   logic [SQ_W-1:0]       s1_sqx_ff, s1_sqy_ff;
   logic [IDX_W-1:0]      s1_idx_ff;
   logic [COORD_BITS-1:0] s1_y_ff;
   logic                  s1_vld_ff, s1_act_ff;

   assign dx = (cell_x[0] > px_ff) ? cell_x[0] - px_ff : px_ff - cell_x[0];
   assign dy = (cell_y[0] > py_ff) ? cell_y[0] - py_ff : py_ff - cell_y[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= ring_shift;
      end
      s1_sqx_ff <= dx * dx;
      s1_sqy_ff <= dy * dy;
      s1_idx_ff <= cnt_ff[IDX_W-1:0];
      s1_y_ff   <= cell_y[0];
      s1_act_ff <= (cnt_ff < n_ff);
   end

   // marks memory with row valid bits
   logic [NUM_MOVERS-1:0] marks_mem [MAX_POINTS];
   logic [MAX_POINTS-1:0] mark_vld_ff;
   logic [NUM_MOVERS-1:0] s1_marks_ff;
   logic                  s1_rowv_ff;
   logic [NUM_MOVERS-1:0] row_old, row_new;
   logic                  mark_we;

   always_ff @(posedge clock) begin
      s1_marks_ff <= marks_mem[cnt_ff[IDX_W-1:0]];
      s1_rowv_ff  <= mark_vld_ff[cnt_ff[IDX_W-1:0]];
      if (mark_we) begin
         marks_mem[s1_idx_ff] <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_vld_ff <= '0;
      end else if (accept && (req_chan.cmd == CMD_CLEAR_MARKS)) begin
         mark_vld_ff <= '0;
      end else if (mark_we) begin
         mark_vld_ff[s1_idx_ff] <= 1'b1;
      end
   end

   // stage 1: distance compare and best tracking
   logic [D2_W-1:0]       d2;
   logic                  now_in, was_in;
   logic [D2_W-1:0]       best_all_ff, best_new_ff;
   logic                  have_new_ff;
   logic [IDX_W-1:0]      new_idx_ff;
   logic [COORD_BITS-1:0] new_y_ff;

   assign d2      = {1'b0, s1_sqx_ff} + {1'b0, s1_sqy_ff};
   assign now_in  = (32'(d2) < 32'(r2_ff));
   assign row_old = s1_rowv_ff ? s1_marks_ff : '0;
   assign was_in  = row_old[midx_ff];
   assign mark_we = s1_vld_ff && s1_act_ff;

   always_comb begin
      row_new          = row_old;
      row_new[midx_ff] = now_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_new_ff <= 1'b0;
      end else if (accept) begin
         have_new_ff <= 1'b0;
      end else if (mark_we && now_in && !was_in && (!have_new_ff || d2 < best_new_ff)) begin
         have_new_ff <= 1'b1;
      end
      if (mark_we) begin
         if (s1_idx_ff == '0 || d2 < best_all_ff) begin
            best_all_ff <= d2;
         end
         if (now_in && !was_in && (!have_new_ff || d2 < best_new_ff)) begin
            best_new_ff <= d2;
            new_idx_ff  <= s1_idx_ff;
            new_y_ff    <= s1_y_ff;
         end
      end
   end

   // pitch math: product, then numerator and divide
   logic signed [DIFF_W-1:0] pdiff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [NUM_W-1:0]  num;
   logic [NUM_W-1:0]         num_mag;
   logic [NUM_W-1:0]         dividend;
   logic [DEN_W-1:0]         den;
   logic                     neg_ff;
   logic                     div_start, sq_start;

   assign pdiff = $signed(DIFF_W'(h_eff)) - $signed(DIFF_W'({new_y_ff, 1'b0}));
   assign num   = NUM_W'(prod_ff) + $signed(NUM_W'(h_eff));
   assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign den      = {h_eff, 1'b0};
   assign dividend = num[NUM_W-1] ? num_mag + NUM_W'(den) - NUM_W'(1) : num_mag;
   assign sq_start  = (state_ff == ST_PITCH1);
   assign div_start = (state_ff == ST_PITCH2);

   always_ff @(posedge clock) begin
      if (state_ff == ST_PITCH1) begin
         prod_ff <= PROD_W'($signed({2'b00, span_eff, 1'b0}) * pdiff);
      end
      if (state_ff == ST_PITCH2) begin
         neg_ff <= num[NUM_W-1];
      end
   end

   pet_unit_stat_type dv_stat, sq_stat;
   logic [NUM_W-1:0]  quo;
   logic [ROOT_W-1:0] root;

   pet_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (den),
      .stat     (dv_stat),
      .quotient (quo)
   );

   pet_sqrt #(.IN_W(SQI_W)) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value ({1'b0, best_all_ff}),
      .stat  (sq_stat),
      .root  (root)
   );

   // signed, saturated pitch
   logic signed [NUM_W:0]    q_s;
   logic signed [NUM_W:0]    span_s;
   logic signed [PITCH_W-1:0] pitch_sat;

   assign q_s    = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign span_s = $signed((NUM_W + 1)'(span_eff));

   always_comb begin
      if (q_s > span_s) begin
         pitch_sat = PITCH_W'(span_s);
      end else if (q_s < -span_s) begin
         pitch_sat = PITCH_W'(-span_s);
      end else begin
         pitch_sat = PITCH_W'(q_s);
      end
   end

   // held pitch per mover
   logic signed [PITCH_W-1:0] held_ff [NUM_MOVERS];
   logic                      units_done;
   assign units_done = dv_stat.done && !dv_stat.busy && sq_stat.done && !sq_stat.busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MOVERS; m++) begin
            held_ff[m] <= '0;
         end
      end else if (state_ff == ST_WAIT && units_done && have_new_ff) begin
         held_ff[midx_ff] <= pitch_sat;
      end
   end

   // pending result
   logic                      pend_entered_ff;
   logic [PIDX_W-1:0]         pend_point_ff;
   logic signed [PITCH_W-1:0] pend_pitch_ff;
   logic [DIST_W-1:0]         pend_dist_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_entered_ff <= 1'b0;
         pend_point_ff   <= '0;
         pend_pitch_ff   <= '0;
         pend_dist_ff    <= '0;
      end else if (state_ff == ST_WAIT && units_done) begin
         pend_entered_ff <= have_new_ff;
         pend_point_ff   <= have_new_ff ? PIDX_W'(new_idx_ff) : '0;
         pend_pitch_ff   <= have_new_ff ? pitch_sat : held_ff[midx_ff];
         pend_dist_ff    <= DIST_W'(root);
      end
   end

   // sequencer
   logic rsp_free;
   assign rsp_free = !rsp_chan.valid || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = '0;
               state_in = is_step ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_POINTS - 1)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH:  state_in = ST_PITCH1;
         ST_PITCH1: state_in = ST_PITCH2;
         ST_PITCH2: state_in = ST_WAIT;
         ST_WAIT: begin
            if (units_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // step operands latched at accept
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff   <= req_chan.pos_x;
         py_ff   <= req_chan.pos_y;
         midx_ff <= MV_W'(req_chan.mover_index);
         r2_ff   <= radius_ff * radius_ff;
         if (act_ff == '0) begin
            n_ff <= CNT_W'(1);
         end else if (32'(act_ff) > MAX_POINTS) begin
            n_ff <= CNT_W'(MAX_POINTS);
         end else begin
            n_ff <= CNT_W'(act_ff);
         end
      end
   end

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_entered_ff;
   logic [PIDX_W-1:0]         rsp_point_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;
   logic [DIST_W-1:0]         rsp_dist_ff;
   logic                      rsp_load;

   assign rsp_load = (state_ff == ST_DONE) && rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_entered_ff <= pend_entered_ff;
         rsp_point_ff   <= pend_point_ff;
         rsp_pitch_ff   <= pend_pitch_ff;
         rsp_dist_ff    <= pend_dist_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.entered       = rsp_entered_ff;
   assign rsp_chan.entered_point = rsp_point_ff;
   assign rsp_chan.pitch_mv      = rsp_pitch_ff;
   assign rsp_chan.nearest_dist  = rsp_dist_ff;
endmodule
`default_nettype wire

// ===== tb/proximity_entry_trigger_core_test.sv =====
// Self-checking testbench of the proximity entry trigger core.
`timescale 1ns / 1ps
module proximity_entry_trigger_core_test;
   import pet_pkg::*;

   localparam int NPTS       = 64;
   localparam int NMOV       = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  cmd;
      logic [5:0]  pidx;
      logic [1:0]  midx;
      logic [11:0] x;
      logic [11:0] y;
   } pet_item_type;

   typedef struct {
      logic               entered;
      logic [5:0]         point;
      logic signed [13:0] pitch;
      logic [12:0]        near_dist;
   } pet_result_type;

   typedef struct {
      pet_item_type   item;
      logic           typed;
      pet_result_type res;
   } pet_row_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pet_req_if #(.COORD_BITS(12)) req_chan ();
   pet_rsp_if rsp_chan ();

   proximity_entry_trigger_core i_dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the block: table, marks, held pitches, registers
   logic [11:0]        tab_x [NPTS];
   logic [11:0]        tab_y [NPTS];
   logic [NPTS-1:0]    marks [NMOV];
   logic signed [13:0] held [NMOV];
   logic [6:0]         reg_active;
   logic [11:0]        reg_radius;
   logic [11:0]        reg_height;
   logic [12:0]        reg_span;

   pet_result_type pending_results[$];
   int errors = 0;
   int n_results = 0;
   int n_steps = 0;
   int n_entries = 0;
   int cycles = 0;
   logic [11:0] mover_x [NMOV];
   logic [11:0] mover_y [NMOV];

   function automatic longint floor_sqrt(longint v);
      longint res = 0;
      longint b = longint'(1) << 30;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic signed [13:0] pitch_of_y(logic [11:0] y);
      longint span = (reg_span > 5000) ? 5000 : longint'(reg_span);
      longint h = (reg_height == 0) ? 1 : longint'(reg_height);
      longint num = 2 * span * (h - 2 * longint'(y)) + h;
      longint den = 2 * h;
      longint q = num / den;
      if ((num % den) != 0 && num < 0) q--;
      if (q > span) q = span;
      if (q < -span) q = -span;
      return 14'(q);
   endfunction

   // apply one accepted item to the shadow, return its result
   function automatic pet_result_type apply_item(pet_item_type it);
      pet_result_type r = '{1'b0, 6'd0, 14'sd0, 13'd0};
      int n;
      longint r2, d2, dx, dy, best_all, best_new;
      logic have_new, now_in;
      int new_idx;
      case (it.cmd)
         CMD_WRITE_POINT: begin
            tab_x[it.pidx] = it.x;
            tab_y[it.pidx] = it.y;
         end
         CMD_CLEAR_MARKS: begin
            for (int m = 0; m < NMOV; m++) marks[m] = '0;
         end
         CMD_STEP_MOVER: begin
            n = (reg_active < 1) ? 1 : (reg_active > NPTS) ? NPTS : int'(reg_active);
            r2 = longint'(reg_radius) * longint'(reg_radius);
            best_all = 0;
            best_new = 0;
            have_new = 1'b0;
            new_idx = 0;
            for (int i = 0; i < n; i++) begin
               dx = longint'(tab_x[i]) - longint'(it.x);
               dy = longint'(tab_y[i]) - longint'(it.y);
               d2 = dx * dx + dy * dy;
               now_in = d2 < r2;
               if (i == 0 || d2 < best_all) best_all = d2;
               if (now_in && !marks[it.midx][i] && (!have_new || d2 < best_new)) begin
                  have_new = 1'b1;
                  best_new = d2;
                  new_idx = i;
               end
               marks[it.midx][i] = now_in;
            end
            if (have_new) held[it.midx] = pitch_of_y(tab_y[new_idx]);
            r.entered = have_new;
            r.point = have_new ? 6'(new_idx) : 6'd0;
            r.pitch = held[it.midx];
            r.near_dist = 13'(floor_sqrt(best_all));
            n_steps++;
            if (have_new) n_entries++;
         end
         default: ;
      endcase
      return r;
   endfunction

   // offer one item and wait for its acceptance
   task automatic offer_item(pet_item_type it, logic typed, pet_result_type typed_res);
      pet_result_type r;
      req_chan.valid <= 1'b1;
      req_chan.cmd <= it.cmd;
      req_chan.point_index <= it.pidx;
      req_chan.mover_index <= it.midx;
      req_chan.pos_x <= it.x;
      req_chan.pos_y <= it.y;
      do @(posedge clock); while (!req_chan.ready);
      r = apply_item(it);
      pending_results.push_back(typed ? typed_res : r);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_ACTIVE_POINTS:  reg_active = val[6:0];
         CSR_CONNECT_RADIUS: reg_radius = val[11:0];
         CSR_FIELD_HEIGHT:   reg_height = val[11:0];
         CSR_PITCH_SPAN_MV:  reg_span = val[12:0];
         default: ;
      endcase
   endtask

   // wait until the block is idle, then load all four registers
   task automatic load_regs(int act, int rad, int hgt, int span);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_ACTIVE_POINTS, 13'(act));
      write_reg(CSR_CONNECT_RADIUS, 13'(rad));
      write_reg(CSR_FIELD_HEIGHT, 13'(hgt));
      write_reg(CSR_PITCH_SPAN_MV, 13'(span));
      csr_we <= 1'b0;
   endtask

   // random item: mostly mover steps near a table point or the mover's last spot, some writes, clears and unused items
   function automatic pet_item_type make_item();
      pet_item_type it;
      int pick = $urandom_range(0, 99);
      int p;
      it.pidx = 6'($urandom_range(0, 63));
      it.midx = 2'($urandom_range(0, 3));
      it.x = 12'($urandom);
      it.y = 12'($urandom);
      if (pick < 62) begin
         it.cmd = CMD_STEP_MOVER;
         if ($urandom_range(0, 3) == 0) begin
            p = $urandom_range(0, 63);
            it.x = tab_x[p] + 12'($urandom_range(0, 700)) - 12'd350;
            it.y = tab_y[p] + 12'($urandom_range(0, 700)) - 12'd350;
         end else if ($urandom_range(0, 4) != 0) begin
            it.x = mover_x[it.midx] + 12'($urandom_range(0, 400)) - 12'd200;
            it.y = mover_y[it.midx] + 12'($urandom_range(0, 400)) - 12'd200;
         end
         mover_x[it.midx] = it.x;
         mover_y[it.midx] = it.y;
      end else if (pick < 88) begin
         it.cmd = CMD_WRITE_POINT;
      end else if (pick < 95) begin
         it.cmd = CMD_CLEAR_MARKS;
      end else begin
         it.cmd = CMD_UNUSED;
      end
      return it;
   endfunction

   // result checker
   always @(posedge clock) begin
      pet_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result entered=%0d point=%0d pitch=%0d dist=%0d",
                     $time, rsp_chan.entered, rsp_chan.entered_point,
                     rsp_chan.pitch_mv, rsp_chan.nearest_dist);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_chan.entered !== e.entered) begin
               $display("%0t: entered expected %0d actual %0d",
                        $time, e.entered, rsp_chan.entered);
               errors++;
            end
            if (rsp_chan.entered_point !== e.point) begin
               $display("%0t: entered_point expected %0d actual %0d",
                        $time, e.point, rsp_chan.entered_point);
               errors++;
            end
            if (rsp_chan.pitch_mv !== e.pitch) begin
               $display("%0t: pitch_mv expected %0d actual %0d",
                        $time, e.pitch, rsp_chan.pitch_mv);
               errors++;
            end
            if (rsp_chan.nearest_dist !== e.near_dist) begin
               $display("%0t: nearest_dist expected %0d actual %0d",
                        $time, e.near_dist, rsp_chan.nearest_dist);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, calm stretches, and one long hold-off
   int hold_left = 0;
   logic hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!hold_done && n_results >= 200) begin
         hold_done <= 1'b1;
         hold_left <= 600;
         rsp_chan.ready <= 1'b0;
      end else if (cycles[10:9] == 2'd0) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   pet_row_type rows[$];

   function automatic pet_row_type row(logic [1:0] c, int p, int m, int x, int y,
                                       logic typed = 1'b0, logic en = 1'b0, int pt = 0,
                                       int pitch = 0, int ndist = 0);
      pet_row_type r;
      r.item = '{c, 6'(p), 2'(m), 12'(x), 12'(y)};
      r.typed = typed;
      r.res = '{en, 6'(pt), 14'(pitch), 13'(ndist)};
      return r;
   endfunction

   initial begin
      pet_item_type it;
      int burst_left, gaps_on;
      pet_result_type none_res;
      none_res = '{1'b0, 6'd0, 14'sd0, 13'd0};
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.cmd <= CMD_WRITE_POINT;
      req_chan.point_index <= '0;
      req_chan.mover_index <= '0;
      req_chan.pos_x <= '0;
      req_chan.pos_y <= '0;
      for (int i = 0; i < NPTS; i++) begin
         tab_x[i] = '0;
         tab_y[i] = '0;
      end
      for (int m = 0; m < NMOV; m++) begin
         marks[m] = '0;
         held[m] = '0;
         mover_x[m] = 12'($urandom);
         mover_y[m] = 12'($urandom);
      end
      reg_active = RST_ACTIVE_POINTS;
      reg_radius = RST_CONNECT_RADIUS;
      reg_height = RST_FIELD_HEIGHT;
      reg_span = RST_PITCH_SPAN_MV;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill the whole table so no step reads an unwritten point
      for (int i = 0; i < NPTS; i++)
         offer_item('{CMD_WRITE_POINT, 6'(i), 2'd0, 12'($urandom), 12'($urandom)},
                    1'b1, none_res);

      // directed items at reset settings
      rows.push_back(row(CMD_UNUSED, 63, 3, 4095, 4095, 1'b1));
      rows.push_back(row(CMD_CLEAR_MARKS, 0, 0, 0, 0, 1'b1));
      rows.push_back(row(CMD_WRITE_POINT, 0, 0, 0, 0, 1'b1));
      rows.push_back(row(CMD_WRITE_POINT, 63, 0, 4095, 4095, 1'b1));
      rows.push_back(row(CMD_STEP_MOVER, 0, 0, 0, 0, 1'b1, 1'b1, 0, 2000, 0));
      rows.push_back(row(CMD_STEP_MOVER, 0, 0, 0, 0, 1'b1, 1'b0, 0, 2000, 0));
      rows.push_back(row(CMD_STEP_MOVER, 0, 1, 4095, 4095));
      rows.push_back(row(CMD_STEP_MOVER, 0, 3, 4095, 0));
      rows.push_back(row(CMD_STEP_MOVER, 0, 2, 0, 4095));
      rows.push_back(row(CMD_STEP_MOVER, 0, 3, 2048, 2048));
      rows.push_back(row(CMD_CLEAR_MARKS, 0, 0, 0, 0, 1'b1));
      rows.push_back(row(CMD_STEP_MOVER, 0, 0, 0, 0, 1'b1, 1'b1, 0, 2000, 0));
      rows.push_back(row(CMD_WRITE_POINT, 0, 0, 4095, 4095, 1'b1));
      rows.push_back(row(CMD_STEP_MOVER, 0, 0, 4095, 4095));
      rows.push_back(row(CMD_STEP_MOVER, 0, 1, 2000, 100));
      foreach (rows[k]) offer_item(rows[k].item, rows[k].typed, rows[k].res);
      req_chan.valid <= 1'b0;

      // random phases over several register settings, extremes included
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_regs(64, 2400, 4095, 5000);
            1: load_regs(0, 0, 0, 8191);
            2: load_regs(127, 4095, 1, 0);
            3: load_regs(1, 2400, 4095, 5000);
            4: load_regs(16, 640, 2144, 2000);
            default: load_regs($urandom_range(0, 127), $urandom_range(0, 4095),
                               $urandom_range(0, 4095), $urandom_range(0, 8191));
         endcase
         gaps_on = (ph % 3 != 1);
         burst_left = $urandom_range(1, 20);
         for (int k = 0; k < 150; k++) begin
            it = make_item();
            offer_item(it, 1'b0, none_res);
            burst_left = burst_left - 1;
            if (gaps_on && burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               req_chan.valid <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
         req_chan.valid <= 1'b0;
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("Covered %0d results, %0d mover steps with %0d entries,", n_results, n_steps,
               n_entries);
      $display("over 9 register settings with bursty input and stalled output.");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/pet_pkg.sv
sv/pet_if.sv
sv/pet_cell.sv
sv/pet_sqrt.sv
sv/pet_div.sv
sv/proximity_entry_trigger_core.sv
tb/proximity_entry_trigger_core_test.sv
